// ===== sv/max_flow_bfs_augment_assert.svh =====
// assertion macros used by the checker file
`ifndef MAX_FLOW_BFS_AUGMENT_ASSERT_SVH
`define MAX_FLOW_BFS_AUGMENT_ASSERT_SVH

// clocked assertion, off while reset is held
`define MFB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("max flow block check failed");

// clocked assertion that stays on through reset
`define MFB_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("max flow block reset check failed");

`endif

// ===== sv/mfb_pkg.sv =====
package mfb_pkg;

    localparam int NODES      = 8;
    localparam int NODE_BITS  = 3;
    localparam int ADDR_BITS  = 2 * NODE_BITS;
    localparam int CAP_BITS   = 16;
    localparam int FLOW_BITS  = 17;
    localparam int RES_BITS   = 18;
    localparam int TOTAL_BITS = 19;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic cap_wr;
        logic rd_entry;
        logic run_clr;
        logic bfs_init;
        logic deq;
        logic scan_rd;
        logic scan_ev;
        logic min_rd;
        logic min_ev;
        logic aug_rd;
        logic aug_wr1;
        logic aug_wr2;
        logic out_run;
        logic out_read;
    } mfb_cmd_t;

    typedef struct packed {
        logic q_empty;
        logic deq_is_sink;
        logic scan_last;
        logic walk_at_src;
        logic min_pos;
        logic out_free;
    } mfb_stat_t;

endpackage

// ===== sv/mfb_ram.sv =====
module mfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/mfb_ctrl.sv =====
module mfb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic [1:0]        opcode,
    output logic              s_tready,
    input  mfb_pkg::mfb_stat_t stat,
    output mfb_pkg::mfb_cmd_t  cmd
);
    import mfb_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_READ    = 13'b0000000000010,
        ST_CLR     = 13'b0000000000100,
        ST_BFS     = 13'b0000000001000,
        ST_DEQ     = 13'b0000000010000,
        ST_SCAN_RD = 13'b0000000100000,
        ST_SCAN_EV = 13'b0000001000000,
        ST_MIN_RD  = 13'b0000010000000,
        ST_MIN_EV  = 13'b0000100000000,
        ST_AUG_RD  = 13'b0001000000000,
        ST_AUG_WR1 = 13'b0010000000000,
        ST_AUG_WR2 = 13'b0100000000000,
        ST_DONE    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    case (opcode)
                        OP_WRITE: cmd.cap_wr = 1'b1;
                        OP_RUN:   state_next = ST_CLR;
                        OP_READ: begin
                            cmd.rd_entry = 1'b1;
                            state_next   = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (stat.out_free) begin
                    cmd.out_read = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CLR: begin
                cmd.run_clr = 1'b1;
                state_next  = ST_BFS;
            end
            ST_BFS: begin
                cmd.bfs_init = 1'b1;
                state_next   = ST_DEQ;
            end
            ST_DEQ: begin
                if (stat.q_empty) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.deq    = 1'b1;
                    state_next = stat.deq_is_sink ? ST_MIN_RD : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_EV;
            end
            ST_SCAN_EV: begin
                cmd.scan_ev = 1'b1;
                state_next  = stat.scan_last ? ST_DEQ : ST_SCAN_RD;
            end
            ST_MIN_RD: begin
                cmd.min_rd = 1'b1;
                state_next = ST_MIN_EV;
            end
            ST_MIN_EV: begin
                cmd.min_ev = 1'b1;
                if (stat.walk_at_src) begin
                    state_next = stat.min_pos ? ST_AUG_RD : ST_DONE;
                end else begin
                    state_next = ST_MIN_RD;
                end
            end
            ST_AUG_RD: begin
                cmd.aug_rd = 1'b1;
                state_next = ST_AUG_WR1;
            end
            ST_AUG_WR1: begin
                cmd.aug_wr1 = 1'b1;
                state_next  = ST_AUG_WR2;
            end
            ST_AUG_WR2: begin
                cmd.aug_wr2 = 1'b1;
                state_next  = stat.walk_at_src ? ST_BFS : ST_AUG_RD;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_run = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== sv/mfb_dp.sv =====
module mfb_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mfb_pkg::mfb_cmd_t              cmd,
    output mfb_pkg::mfb_stat_t             stat,
    input  logic [mfb_pkg::NODE_BITS-1:0]  node_last,
    input  logic [mfb_pkg::NODE_BITS-1:0]  from_node,
    input  logic [mfb_pkg::NODE_BITS-1:0]  to_node,
    input  logic [mfb_pkg::CAP_BITS-1:0]   capacity,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic                           result_kind,
    output logic [mfb_pkg::TOTAL_BITS-1:0] max_flow,
    output logic [mfb_pkg::FLOW_BITS-1:0]  entry_flow,
    output logic [mfb_pkg::FLOW_BITS-1:0]  entry_residual
);
    import mfb_pkg::*;

    localparam int DEPTH = NODES * NODES;

    logic [DEPTH-1:0]     cap_vld_reg;
    logic [DEPTH-1:0]     flow_vld_reg;
    logic                 cap_vq_reg, flow_vq_reg;
    logic [NODES-1:0]     visited_reg;
    logic [NODE_BITS-1:0] parent_reg [NODES];
    logic [NODE_BITS-1:0] queue_reg [NODES];
    logic [NODE_BITS-1:0] head_reg, tail_reg;
    logic [NODE_BITS-1:0] u_reg, v_reg, w_reg;
    logic signed [RES_BITS-1:0]  min_reg;
    logic signed [FLOW_BITS-1:0] new_flow_reg;
    logic [TOTAL_BITS-1:0] total_reg;

    logic                  m_tvalid_reg;
    logic                  kind_reg;
    logic [TOTAL_BITS-1:0] max_flow_reg;
    logic [FLOW_BITS-1:0]  eflow_reg, eres_reg;

    logic                 cap_we, flow_we, rd_en;
    logic [ADDR_BITS-1:0] cap_waddr, flow_waddr, raddr;
    logic [FLOW_BITS-1:0] flow_wdata;
    logic [CAP_BITS-1:0]  cap_raw, cap_q;
    logic [FLOW_BITS-1:0] flow_raw;
    logic signed [FLOW_BITS-1:0] flow_q;
    logic signed [RES_BITS-1:0]  res_q, min_next;
    logic [NODE_BITS-1:0] par_w;
    logic [TOTAL_BITS:0]  total_sum;

    assign par_w = parent_reg[w_reg];

    // read address shared by both stores
    always_comb begin
        rd_en = cmd.rd_entry | cmd.scan_rd | cmd.min_rd | cmd.aug_rd;
        if (cmd.rd_entry) begin
            raddr = {from_node, to_node};
        end else if (cmd.scan_rd) begin
            raddr = {u_reg, v_reg};
        end else begin
            raddr = {par_w, w_reg};
        end
    end

    assign cap_we     = cmd.cap_wr;
    assign cap_waddr  = {from_node, to_node};
    assign flow_we    = cmd.aug_wr1 | cmd.aug_wr2;
    assign flow_waddr = cmd.aug_wr1 ? {par_w, w_reg} : {w_reg, par_w};
    assign flow_wdata = cmd.aug_wr1 ? (FLOW_BITS'(flow_q) + FLOW_BITS'(min_reg))
                                    : FLOW_BITS'(-new_flow_reg);

    mfb_ram #(.WIDTH(CAP_BITS), .DEPTH(DEPTH)) u_cap_ram (
        .aclk(aclk), .we(cap_we), .waddr(cap_waddr), .wdata(capacity),
        .re(rd_en), .raddr(raddr), .rdata(cap_raw)
    );

    mfb_ram #(.WIDTH(FLOW_BITS), .DEPTH(DEPTH)) u_flow_ram (
        .aclk(aclk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
        .re(rd_en), .raddr(raddr), .rdata(flow_raw)
    );

    assign cap_q    = cap_vq_reg ? cap_raw : '0;
    assign flow_q   = flow_vq_reg ? signed'(flow_raw) : '0;
    assign res_q    = signed'({2'b00, cap_q}) - RES_BITS'(flow_q);
    assign min_next = (res_q < min_reg) ? res_q : min_reg;
    assign total_sum = {1'b0, total_reg} + (TOTAL_BITS + 1)'(min_reg[FLOW_BITS-1:0]);

    assign stat.q_empty     = (head_reg == tail_reg);
    assign stat.deq_is_sink = (queue_reg[head_reg] == NODE_BITS'(1));
    assign stat.scan_last   = (v_reg == node_last);
    assign stat.walk_at_src = (par_w == '0);
    assign stat.min_pos     = (min_next > 0);
    assign stat.out_free    = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_vld_reg  <= '0;
            flow_vld_reg <= '0;
            total_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            visited_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cap_we) begin
                cap_vld_reg[cap_waddr] <= 1'b1;
            end
            if (rd_en) begin
                cap_vq_reg  <= cap_vld_reg[raddr];
                flow_vq_reg <= flow_vld_reg[raddr];
            end
            if (cmd.run_clr) begin
                flow_vld_reg <= '0;
                total_reg    <= '0;
            end else if (flow_we) begin
                flow_vld_reg[flow_waddr] <= 1'b1;
            end
            if (cmd.bfs_init) begin
                visited_reg    <= NODES'(1);
                queue_reg[0]   <= '0;
                head_reg       <= '0;
                tail_reg       <= NODE_BITS'(1);
            end
            if (cmd.deq) begin
                u_reg    <= queue_reg[head_reg];
                head_reg <= head_reg + 1'b1;
                v_reg    <= '0;
                w_reg    <= NODE_BITS'(1);
                min_reg  <= {1'b0, {(RES_BITS-1){1'b1}}};
            end
            if (cmd.scan_ev) begin
                v_reg <= v_reg + 1'b1;
                if (res_q != 0 && !visited_reg[v_reg]) begin
                    visited_reg[v_reg] <= 1'b1;
                    parent_reg[v_reg]  <= u_reg;
                    queue_reg[tail_reg] <= v_reg;
                    tail_reg <= tail_reg + 1'b1;
                end
            end
            if (cmd.min_ev) begin
                min_reg <= min_next;
                w_reg   <= stat.walk_at_src ? NODE_BITS'(1) : par_w;
            end
            if (cmd.aug_wr1) begin
                new_flow_reg <= signed'(flow_wdata);
            end
            if (cmd.aug_wr2) begin
                w_reg <= par_w;
                if (stat.walk_at_src) begin
                    total_reg <= total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];
                end
            end
            if (cmd.out_run || cmd.out_read) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (cmd.out_run) begin
            kind_reg     <= KIND_RUN;
            max_flow_reg <= total_reg;
            eflow_reg    <= '0;
            eres_reg     <= '0;
        end else if (cmd.out_read) begin
            kind_reg     <= KIND_READ;
            max_flow_reg <= '0;
            eflow_reg    <= FLOW_BITS'(flow_q);
            eres_reg     <= res_q[FLOW_BITS-1:0];
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign result_kind    = kind_reg;
    assign max_flow       = max_flow_reg;
    assign entry_flow     = eflow_reg;
    assign entry_residual = eres_reg;
endmodule

// ===== sv/max_flow_bfs_augment.sv =====
// channel   | direction | tdata (low bit up)                               | tuser
// s_ stream | in        | from_node, to_node, capacity                     | opcode
// m_ stream | out       | max_flow, entry_flow, entry_residual             | result_kind
// cfg port  | in        | node_count                                       | -
// a capacity write completes in the idle state; an entry read passes through the read state, then the output hand-off
// a run repeats a breadth-first search, each dequeued node scanning all nodes with a read and an
// evaluate state, then a minimum walk and an augment walk (read, two writes) along the path found
// reset clears capacities, flows and the output valid flag, and loads node_count (8), at once
// input is held while a run or read is in progress or its result cannot be stored
module max_flow_bfs_augment (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // from_node[2:0], to_node[5:3], capacity[21:6]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // max_flow[18:0], entry_flow[35:19], entry_residual[52:36]
    output logic        m_tuser,   // result_kind[0]
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data
);
    import mfb_pkg::*;

    mfb_cmd_t  cmd;
    mfb_stat_t stat;

    logic [3:0]            node_count_reg;
    logic [NODE_BITS-1:0]  node_last;
    logic [TOTAL_BITS-1:0] max_flow;
    logic [FLOW_BITS-1:0]  entry_flow, entry_residual;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 4'd8;
        end else if (cfg_wr_en) begin
            node_count_reg <= cfg_wr_data;
        end
    end

    // clamp node count into 2..NODES, keep last index
    always_comb begin
        if (node_count_reg < 4'd2) begin
            node_last = NODE_BITS'(1);
        end else if (node_count_reg > 4'(NODES)) begin
            node_last = NODE_BITS'(NODES - 1);
        end else begin
            node_last = NODE_BITS'(node_count_reg - 4'd1);
        end
    end

    mfb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .opcode(s_tuser),
        .s_tready(s_tready), .stat(stat), .cmd(cmd)
    );

    mfb_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .node_last(node_last), .from_node(s_tdata[2:0]), .to_node(s_tdata[5:3]),
        .capacity(s_tdata[21:6]), .m_tready(m_tready), .m_tvalid(m_tvalid),
        .result_kind(m_tuser), .max_flow(max_flow), .entry_flow(entry_flow),
        .entry_residual(entry_residual)
    );

    assign m_tdata = {3'b000, entry_residual, entry_flow, max_flow};
endmodule

// ===== sv/mfb_checker.sv =====
module mfb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);
`include "max_flow_bfs_augment_assert.svh"

    `MFB_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid)
    `MFB_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata))
    `MFB_ASSERT(a_read_no_total, m_tvalid && m_tuser |-> m_tdata[18:0] == 19'd0)
    `MFB_ASSERT(a_run_no_entry, m_tvalid && !m_tuser |-> m_tdata[55:19] == 37'd0)
    `MFB_ASSERT_RST(a_reset_idle, !aresetn |=> !m_tvalid)
endmodule

bind max_flow_bfs_augment mfb_checker u_mfb_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
